FILE: rtl/nsf_pkg.sv
// shared types and constants of the nmea sentence framer
package nsf_pkg;

	// character codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] PRINT_LO  = 8'h20;
	localparam logic [7:0] PRINT_HI  = 8'h7E;

	// room kept for '*', two hex digits, cr lf and one spare byte
	localparam logic [12:0] TAIL_ROOM = 13'd6;

	// configuration register indexes
	localparam logic [1:0] CFG_BUFFER_BYTES   = 2'd0;
	localparam logic [1:0] CFG_ABORT_NONPRINT = 2'd1;
	localparam logic [1:0] CFG_ACCEPT_BAD_SUM = 2'd2;

	localparam logic [11:0] BUFFER_BYTES_RST = 12'd82;

	typedef enum logic [3:0] {
		ST_NONE       = 4'd0,
		ST_DONE       = 4'd1,
		ST_BAD_NAME   = 4'd2,
		ST_NAME_LONG  = 4'd3,
		ST_NONPRINT   = 4'd4,
		ST_TOO_LONG   = 4'd5,
		ST_BAD_HEX    = 4'd6,
		ST_BAD_SUM    = 4'd7,
		ST_BUF_SMALL  = 4'd8
	} status_t;

	typedef struct packed {
		logic [11:0] buffer_bytes;
		logic        abort_nonprintable;
		logic        accept_bad_checksum;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic        in_sentence;
		logic [11:0] sentence_length;
		logic [3:0]  name_length;
		logic [63:0] sentence_name;
		logic [7:0]  received_checksum;
		logic [7:0]  computed_checksum;
	} result_t;

endpackage

FILE: rtl/nsf_core.sv
// per-byte sentence state machine and result formation
module nsf_core import nsf_pkg::*; #(
	parameter int NAME_BYTES = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	localparam int NAME_DEPTH = NAME_BYTES - 1;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_NAME    = 8'b0000_0010,
		PH_DATA    = 8'b0000_0100,
		PH_HEX1    = 8'b0000_1000,
		PH_HEX2    = 8'b0001_0000,
		PH_TERM    = 8'b0010_0000,
		PH_WAIT_LF = 8'b0100_0000,
		PH_WAIT_CR = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [11:0] count_q, count_d;
	logic [3:0]  ncount_q, ncount_d;
	logic [7:0]  hex_q, hex_d;
	logic [7:0]  name_q [NAME_DEPTH];
	logic        name_wr;

	logic [11:0] count_inc;
	logic [11:0] len;
	logic [12:0] len_total;
	logic        fits, sum_ok, restart, alnum, nib_ok;
	logic [3:0]  nib;
	logic [7:0]  upper;
	logic [63:0] name_packed;
	status_t     val_status;

	// hex digit value, valid flag in the top bit
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0_0000;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	always_comb begin
		count_inc = (phase_q != PH_IDLE) ? count_q + 12'd1 : count_q;
		len       = count_inc - ((phase_q == PH_TERM) ? 12'd1 : 12'd2);
		len_total = {1'b0, len} + 13'd2;
		fits      = len_total <= {1'b0, cfg.buffer_bytes};
		sum_ok    = (hex_q == xor_q) || cfg.accept_bad_checksum;
		upper     = data_byte & 8'hDF;
		alnum     = (upper >= 8'h41 && upper <= 8'h5A) ||
		            (data_byte >= 8'h30 && data_byte <= 8'h39);
		{nib_ok, nib} = hex_nib(data_byte);
		for (int i = 0; i < 8; i++) begin
			if (i < NAME_DEPTH && 4'(i) < ncount_q) begin
				name_packed[8*i +: 8] = name_q[i];
			end else begin
				name_packed[8*i +: 8] = 8'h00;
			end
		end
		priority if (!fits) begin
			val_status = ST_BUF_SMALL;
		end else if (!sum_ok) begin
			val_status = ST_BAD_SUM;
		end else begin
			val_status = ST_DONE;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		xor_d    = xor_q;
		count_d  = count_inc;
		ncount_d = ncount_q;
		hex_d    = hex_q;
		name_wr  = 1'b0;
		restart  = 1'b0;
		res      = '0;
		unique case (phase_q)
			PH_NAME: begin
				xor_d = xor_q ^ data_byte;
				if (data_byte == CH_COMMA && ncount_q != 4'd0) begin
					phase_d = PH_DATA;
					res.in_sentence = 1'b1;
				end else if (!alnum) begin
					res.status = ST_BAD_NAME;
					restart = 1'b1;
				end else if (ncount_q >= 4'(NAME_DEPTH)) begin
					res.status = ST_NAME_LONG;
					restart = 1'b1;
				end else begin
					name_wr  = 1'b1;
					ncount_d = ncount_q + 4'd1;
					res.in_sentence = 1'b1;
				end
			end
			PH_DATA: begin
				if (data_byte == CH_STAR) begin
					phase_d = PH_HEX1;
					res.in_sentence = 1'b1;
				end else begin
					xor_d = xor_q ^ data_byte;
					if (cfg.abort_nonprintable &&
					    (data_byte < PRINT_LO || data_byte > PRINT_HI)) begin
						res.status = ST_NONPRINT;
						restart = 1'b1;
					end else if ({1'b0, count_inc} + TAIL_ROOM >
					             {1'b0, cfg.buffer_bytes}) begin
						res.status = ST_TOO_LONG;
						restart = 1'b1;
					end else begin
						res.in_sentence = 1'b1;
					end
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (!nib_ok) begin
					res.status = ST_BAD_HEX;
					restart = 1'b1;
				end else begin
					if (phase_q == PH_HEX1) begin
						hex_d   = {nib, 4'h0};
						phase_d = PH_HEX2;
					end else begin
						hex_d   = {hex_q[7:4], nib};
						phase_d = PH_TERM;
					end
					res.in_sentence = 1'b1;
				end
			end
			PH_TERM: begin
				if (data_byte == CH_CR) begin
					phase_d = PH_WAIT_LF;
					res.in_sentence = 1'b1;
				end else if (data_byte == CH_LF) begin
					phase_d = PH_WAIT_CR;
					res.in_sentence = 1'b1;
				end else begin
					res.status = val_status;
					restart = 1'b1;
				end
			end
			PH_WAIT_LF, PH_WAIT_CR: begin
				res.status = val_status;
				if (val_status == ST_DONE &&
				    data_byte == ((phase_q == PH_WAIT_LF) ? CH_LF : CH_CR)) begin
					phase_d = PH_IDLE;
					res.in_sentence = 1'b1;
				end else begin
					restart = 1'b1;
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		if (res.status == ST_DONE) begin
			res.sentence_length   = len_total[11:0];
			res.name_length       = ncount_q;
			res.sentence_name     = name_packed;
			res.received_checksum = hex_q;
			res.computed_checksum = xor_q;
		end

		// the aborting byte may itself open a new sentence
		if (restart) begin
			if (data_byte == CH_DOLLAR) begin
				phase_d  = PH_NAME;
				xor_d    = 8'h00;
				count_d  = 12'd1;
				ncount_d = 4'd0;
				res.in_sentence = 1'b1;
			end else begin
				phase_d = PH_IDLE;
				res.in_sentence = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			xor_q    <= 8'h00;
			count_q  <= 12'd0;
			ncount_q <= 4'd0;
			hex_q    <= 8'h00;
		end else if (take) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			count_q  <= count_d;
			ncount_q <= ncount_d;
			hex_q    <= hex_d;
		end
	end

	// name characters, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < NAME_DEPTH; i++) begin
			if (take && name_wr && ncount_q == 4'(i)) begin
				name_q[i] <= data_byte;
			end
		end
	end

endmodule

FILE: rtl/nsf_result_fifo.sv
// two-entry result buffer between the framer and the output channel
module nsf_result_fifo import nsf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    not_empty,
	output result_t head
);

	result_t    mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/nmea_sentence_framer.sv
// top level of the nmea sentence framer: config registers, framer core, result buffer
// Takes one byte per transfer and returns exactly one result per byte, in order: a
// status code, whether the byte was consumed as part of a sentence, and on a finished
// sentence its length with cr lf, its name and both checksums (those fields are zero
// otherwise). A byte can be taken every clock cycle while the result buffer has room;
// the per-byte decision is combinational logic from the accepted byte and the sentence
// state straight into a two-entry result buffer, whose head is offered on the output
// side. in_stall rises only when both buffer entries hold results that the
// output side has not yet taken. Configuration writes take effect at once and are
// expected only while no byte is in flight.
module nmea_sentence_framer import nsf_pkg::*; #(
	parameter int NAME_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr,
	input  logic [1:0]  cfg_idx,
	input  logic [11:0] cfg_data,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// result output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic        in_sentence,
	output logic [11:0] sentence_length,
	output logic [3:0]  name_length,
	output logic [63:0] sentence_name,
	output logic [7:0]  received_checksum,
	output logic [7:0]  computed_checksum
);

	cfg_t    cfg_q;
	result_t step_res;
	result_t head;
	logic    in_take;
	logic    out_take;
	logic    buf_full;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_bytes        <= BUFFER_BYTES_RST;
			cfg_q.abort_nonprintable  <= 1'b0;
			cfg_q.accept_bad_checksum <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				CFG_BUFFER_BYTES:   cfg_q.buffer_bytes        <= cfg_data;
				CFG_ABORT_NONPRINT: cfg_q.abort_nonprintable  <= cfg_data[0];
				CFG_ACCEPT_BAD_SUM: cfg_q.accept_bad_checksum <= cfg_data[0];
				default:            cfg_q                     <= cfg_q;
			endcase
		end
	end

	// input transfer whenever the result buffer has room
	assign in_stall = buf_full;
	assign in_take  = in_valid && !buf_full;
	assign out_take = out_valid && !out_stall;

	nsf_core #(
		.NAME_BYTES(NAME_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (in_take),
		.data_byte(data_byte),
		.cfg      (cfg_q),
		.res      (step_res)
	);

	// decouples the byte side from a stalled output side
	nsf_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_take),
		.push_data(step_res),
		.pop      (out_take),
		.full     (buf_full),
		.not_empty(out_valid),
		.head     (head)
	);

	// result fields from the buffer head
	assign status            = head.status;
	assign in_sentence       = head.in_sentence;
	assign sentence_length   = head.sentence_length;
	assign name_length       = head.name_length;
	assign sentence_name     = head.sentence_name;
	assign received_checksum = head.received_checksum;
	assign computed_checksum = head.computed_checksum;

endmodule

FILE: bench/nmea_sentence_framer_tb.sv
// self-checking testbench of the nmea sentence framer, byte stream in, one result per byte out
module nmea_sentence_framer_tb;
	import nsf_pkg::*;

	localparam int NAME_BYTES = 9;
	// generous bound: every byte waiting out long sender gaps and receiver stalls
	localparam int CYCLE_LIMIT = 400000;

	// sentence phases of the framer, kept by the predictor
	typedef enum logic [2:0] {
		F_IDLE,
		F_NAME,
		F_DATA,
		F_HEX1,
		F_HEX2,
		F_TERM,
		F_WAIT_LF,
		F_WAIT_CR
	} frame_phase_t;

	// one row of the opening stimulus; typed rows carry a hand-written result
	typedef struct {
		logic [7:0] b;
		bit         typed;
		status_t    st;
		logic       ins;
	} plan_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr = 1'b0;
	logic [1:0]  cfg_idx = CFG_BUFFER_BYTES;
	logic [11:0] cfg_data = 12'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  status;
	logic        in_sentence;
	logic [11:0] sentence_length;
	logic [3:0]  name_length;
	logic [63:0] sentence_name;
	logic [7:0]  received_checksum;
	logic [7:0]  computed_checksum;

	// predictor copy of the framer state and its registers
	frame_phase_t fr_phase;
	logic [7:0]   xor_sum;
	logic [11:0]  byte_cnt;
	logic [7:0]   name_chars [NAME_BYTES - 1];
	logic [3:0]   name_cnt;
	logic [7:0]   sum_given;
	logic [11:0]  cap_bytes;
	logic         drop_nonprint;
	logic         take_bad_sum;

	result_t    expected_results [$];
	result_t    want;
	logic [7:0] tx_bytes [$];
	int         mismatches = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;

	// opening stimulus: field extremes, comma first, name too long, lower-case hex,
	// lone lf then a '$' on a bad checksum, bad hex digit, and a wrong ending byte
	plan_row_t opening_plan [34] = '{
		'{8'h00, 1'b1, ST_NONE, 1'b0},
		'{8'hFF, 1'b1, ST_NONE, 1'b0},
		'{CH_DOLLAR, 1'b1, ST_NONE, 1'b1},
		'{CH_COMMA, 1'b1, ST_BAD_NAME, 1'b0},
		'{CH_DOLLAR, 1'b1, ST_NONE, 1'b1},
		'{"A", 1'b0, ST_NONE, 1'b0},
		'{"B", 1'b0, ST_NONE, 1'b0},
		'{"C", 1'b0, ST_NONE, 1'b0},
		'{"D", 1'b0, ST_NONE, 1'b0},
		'{"E", 1'b0, ST_NONE, 1'b0},
		'{"F", 1'b0, ST_NONE, 1'b0},
		'{"G", 1'b0, ST_NONE, 1'b0},
		'{"H", 1'b0, ST_NONE, 1'b0},
		'{"9", 1'b1, ST_NAME_LONG, 1'b0},
		'{CH_DOLLAR, 1'b1, ST_NONE, 1'b1},
		'{"g", 1'b0, ST_NONE, 1'b0},
		'{CH_COMMA, 1'b0, ST_NONE, 1'b0},
		'{8'h7F, 1'b0, ST_NONE, 1'b0},
		'{CH_STAR, 1'b0, ST_NONE, 1'b0},
		'{"f", 1'b0, ST_NONE, 1'b0},
		'{"F", 1'b0, ST_NONE, 1'b0},
		'{CH_LF, 1'b0, ST_NONE, 1'b0},
		'{CH_DOLLAR, 1'b1, ST_BAD_SUM, 1'b1},
		'{"Q", 1'b0, ST_NONE, 1'b0},
		'{CH_COMMA, 1'b0, ST_NONE, 1'b0},
		'{CH_STAR, 1'b0, ST_NONE, 1'b0},
		'{"x", 1'b1, ST_BAD_HEX, 1'b0},
		'{CH_DOLLAR, 1'b1, ST_NONE, 1'b1},
		'{"P", 1'b0, ST_NONE, 1'b0},
		'{CH_COMMA, 1'b0, ST_NONE, 1'b0},
		'{CH_STAR, 1'b0, ST_NONE, 1'b0},
		'{"7", 1'b0, ST_NONE, 1'b0},
		'{"c", 1'b0, ST_NONE, 1'b0},
		'{CH_DOLLAR, 1'b0, ST_NONE, 1'b0}
	};

	nmea_sentence_framer DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr            (cfg_wr),
		.cfg_idx           (cfg_idx),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.data_byte         (data_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.in_sentence       (in_sentence),
		.sentence_length   (sentence_length),
		.name_length       (name_length),
		.sentence_name     (sentence_name),
		.received_checksum (received_checksum),
		.computed_checksum (computed_checksum)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// value of a hex digit, bit 4 set when the byte is no hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] d);
		if (d >= "0" && d <= "9") return {1'b0, 4'(d - 8'h30)};
		if (d >= "A" && d <= "F") return {1'b0, 4'(d - 8'h41 + 8'd10)};
		if (d >= "a" && d <= "f") return {1'b0, 4'(d - 8'h61 + 8'd10)};
		return 5'h10;
	endfunction

	// after an abort or a finished sentence the byte gets a second look as a '$'
	function automatic logic restart_on(input logic [7:0] d);
		if (d == CH_DOLLAR) begin
			fr_phase = F_NAME;
			xor_sum = 8'd0;
			byte_cnt = 12'd1;
			name_cnt = 4'd0;
			return 1'b1;
		end
		fr_phase = F_IDLE;
		return 1'b0;
	endfunction

	// checks fit and checksum of a terminated sentence; trailing bytes are not counted
	function automatic result_t close_sentence(input logic [11:0] trailing);
		result_t     r;
		logic [11:0] len;
		r = '0;
		len = byte_cnt - trailing;
		if ({1'b0, len} + 13'd2 > {1'b0, cap_bytes}) begin
			r.status = ST_BUF_SMALL;
			return r;
		end
		if (sum_given != xor_sum && !take_bad_sum) begin
			r.status = ST_BAD_SUM;
			return r;
		end
		r.status = ST_DONE;
		r.sentence_length = len + 12'd2;
		r.name_length = name_cnt;
		for (int i = 0; i < NAME_BYTES - 1; i++)
			if (i < name_cnt) r.sentence_name[8 * i +: 8] = name_chars[i];
		r.received_checksum = sum_given;
		r.computed_checksum = xor_sum;
		return r;
	endfunction

	// expected result of one byte; advances the predictor state
	function automatic result_t frame_byte(input logic [7:0] d);
		result_t    r;
		logic [4:0] nib;
		logic [7:0] up;
		r = '0;
		r.status = ST_NONE;
		if (fr_phase != F_IDLE) byte_cnt = byte_cnt + 12'd1;
		case (fr_phase)
			F_NAME: begin
				xor_sum = xor_sum ^ d;
				up = d & 8'hDF;
				if (d == CH_COMMA && name_cnt != 0) begin
					fr_phase = F_DATA;
					r.in_sentence = 1'b1;
				end else if (!((up >= "A" && up <= "Z") || (d >= "0" && d <= "9"))) begin
					r.status = ST_BAD_NAME;
					r.in_sentence = restart_on(d);
				end else if (name_cnt >= NAME_BYTES - 1) begin
					r.status = ST_NAME_LONG;
					r.in_sentence = restart_on(d);
				end else begin
					name_chars[name_cnt] = d;
					name_cnt = name_cnt + 4'd1;
					r.in_sentence = 1'b1;
				end
			end
			F_DATA: begin
				if (d == CH_STAR) begin
					fr_phase = F_HEX1;
					r.in_sentence = 1'b1;
				end else begin
					xor_sum = xor_sum ^ d;
					if (drop_nonprint && (d < PRINT_LO || d > PRINT_HI)) begin
						r.status = ST_NONPRINT;
						r.in_sentence = restart_on(d);
					end else if ({1'b0, byte_cnt} + TAIL_ROOM > {1'b0, cap_bytes}) begin
						r.status = ST_TOO_LONG;
						r.in_sentence = restart_on(d);
					end else begin
						r.in_sentence = 1'b1;
					end
				end
			end
			F_HEX1, F_HEX2: begin
				nib = hex_nibble(d);
				if (nib[4]) begin
					r.status = ST_BAD_HEX;
					r.in_sentence = restart_on(d);
				end else begin
					if (fr_phase == F_HEX1) begin
						sum_given = {nib[3:0], 4'h0};
						fr_phase = F_HEX2;
					end else begin
						sum_given[3:0] = nib[3:0];
						fr_phase = F_TERM;
					end
					r.in_sentence = 1'b1;
				end
			end
			F_TERM: begin
				if (d == CH_CR) begin
					fr_phase = F_WAIT_LF;
					r.in_sentence = 1'b1;
				end else if (d == CH_LF) begin
					fr_phase = F_WAIT_CR;
					r.in_sentence = 1'b1;
				end else begin
					// any other byte still closes the sentence
					r = close_sentence(12'd1);
					r.in_sentence = restart_on(d);
				end
			end
			F_WAIT_LF, F_WAIT_CR: begin
				r = close_sentence(12'd2);
				if (r.status == ST_DONE &&
						d == ((fr_phase == F_WAIT_LF) ? CH_LF : CH_CR)) begin
					fr_phase = F_IDLE;
					r.in_sentence = 1'b1;
				end else begin
					r.in_sentence = restart_on(d);
				end
			end
			default: begin
				r.in_sentence = restart_on(d);
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 35));
		if (c < 8'd10) return 8'h30 + c;
		c = 8'h41 + c - 8'd10;
		if ($urandom_range(0, 1)) c = c | 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	// fills tx_bytes with one burst: mostly a well-formed sentence with random content,
	// sometimes cut short or hit by a stray byte, sometimes plain line noise
	task automatic make_burst();
		int         nlen;
		int         dlen;
		int         sel;
		int         pos;
		logic [7:0] c;
		logic [7:0] sum;
		tx_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		tx_bytes.push_back(CH_DOLLAR);
		sum = 8'd0;
		sel = $urandom_range(0, 19);
		nlen = (sel == 0) ? 0 : (sel == 1) ? NAME_BYTES : $urandom_range(1, NAME_BYTES - 1);
		repeat (nlen) begin
			c = name_char();
			tx_bytes.push_back(c);
			sum = sum ^ c;
		end
		tx_bytes.push_back(CH_COMMA);
		sum = sum ^ CH_COMMA;
		dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
		repeat (dlen) begin
			if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
			else c = 8'($urandom_range(PRINT_LO, PRINT_HI));
			if (c == CH_STAR) c = CH_COMMA;
			tx_bytes.push_back(c);
			sum = sum ^ c;
		end
		tx_bytes.push_back(CH_STAR);
		if ($urandom_range(0, 4) == 0) sum = 8'($urandom_range(0, 255));
		tx_bytes.push_back(hex_char(sum[7:4]));
		tx_bytes.push_back(hex_char(sum[3:0]));
		// ending: cr lf, lf cr, a lone cr or lf, none, or a stray byte
		sel = $urandom_range(0, 9);
		if (sel <= 4) begin
			tx_bytes.push_back(CH_CR);
			tx_bytes.push_back(CH_LF);
		end else if (sel == 5) begin
			tx_bytes.push_back(CH_LF);
			tx_bytes.push_back(CH_CR);
		end else if (sel == 6) begin
			tx_bytes.push_back(CH_CR);
		end else if (sel == 7) begin
			tx_bytes.push_back(CH_LF);
		end else if (sel == 9) begin
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) == 0) begin
			pos = $urandom_range(1, tx_bytes.size() - 1);
			if ($urandom_range(0, 1)) tx_bytes = tx_bytes[0:pos - 1];
			else tx_bytes[pos] = 8'($urandom_range(0, 255));
		end
	endtask

	// one byte transfer; the expectation is queued before the byte can be taken
	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
		result_t pred;
		pred = frame_byte(b);
		expected_results.push_back(typed ? typed_res : pred);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		cfg_wr <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// new register settings, written only once every expected result has come back
	task automatic apply_settings(input logic [11:0] cap, input logic np, input logic bad);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		write_reg(CFG_BUFFER_BYTES, cap);
		write_reg(CFG_ABORT_NONPRINT, {11'd0, np});
		write_reg(CFG_ACCEPT_BAD_SUM, {11'd0, bad});
		cfg_wr <= 1'b0;
		cap_bytes = cap;
		drop_nonprint = np;
		take_bad_sum = bad;
	endtask

	// random bursts until the phase has sent its share of bytes
	task automatic run_frames(input int target);
		int taken;
		taken = 0;
		while (taken < target) begin
			make_burst();
			foreach (tx_bytes[i]) begin
				send_byte(tx_bytes[i], 1'b0, '0);
				taken++;
			end
		end
	endtask

	// receiver stalls at random, at the rate of the current idling mode
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// every result transfer is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result transfer with nothing expected: status %0d in_sentence %0b",
						status, in_sentence);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || in_sentence !== want.in_sentence ||
						sentence_length !== want.sentence_length ||
						name_length !== want.name_length ||
						sentence_name !== want.sentence_name ||
						received_checksum !== want.received_checksum ||
						computed_checksum !== want.computed_checksum) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: exp st %0d ins %0b len %0d nlen %0d name %h rx %h cx %h",
							want.status, want.in_sentence, want.sentence_length,
							want.name_length, want.sentence_name, want.received_checksum,
							want.computed_checksum);
						$display(" | got st %0d ins %0b len %0d nlen %0d name %h rx %h cx %h",
							status, in_sentence, sentence_length,
							name_length, sentence_name, received_checksum, computed_checksum);
					end
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		result_t typed_res;
		// predictor starts from the reset state and reset register values
		fr_phase = F_IDLE;
		xor_sum = 8'd0;
		byte_cnt = 12'd0;
		name_cnt = 4'd0;
		sum_given = 8'd0;
		cap_bytes = BUFFER_BYTES_RST;
		drop_nonprint = 1'b0;
		take_bad_sum = 1'b0;
		foreach (name_chars[i]) name_chars[i] = 8'd0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles a third of the time, receiver two thirds
		send_idle_pct = 33;
		stall_pct = 66;

		// opening table runs on the reset register values
		foreach (opening_plan[i]) begin
			typed_res = '0;
			typed_res.status = opening_plan[i].st;
			typed_res.in_sentence = opening_plan[i].ins;
			send_byte(opening_plan[i].b, opening_plan[i].typed, typed_res);
		end

		apply_settings(BUFFER_BYTES_RST, 1'b0, 1'b0);
		run_frames(205);
		// largest buffer, nonprintable abort, mismatches accepted
		apply_settings(12'd4095, 1'b1, 1'b1);
		run_frames(205);

		// roles swap: sender idles two thirds, receiver a third
		send_idle_pct = 66;
		stall_pct = 33;
		// buffer far below its range so that short sentences no longer fit
		apply_settings(12'd12, 1'b0, 1'b1);
		run_frames(205);
		apply_settings(12'd200, 1'b1, 1'b0);
		run_frames(205);

		// back to back, no idling on either side
		send_idle_pct = 0;
		stall_pct = 0;
		apply_settings(BUFFER_BYTES_RST, 1'b0, 1'b0);
		run_frames(205);
		apply_settings(12'd4095, 1'b0, 1'b0);
		run_frames(205);

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
